[src/ring_buffer_offset_peek_defines.svh]
// Assertion macros for the ring buffer checker.
`ifndef RING_BUFFER_OFFSET_PEEK_DEFINES_SVH
`define RING_BUFFER_OFFSET_PEEK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RBOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RBOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rbop_pkg.sv]
package rbop_pkg;

  localparam int DEPTH    = 1024;
  localparam int SAMPLE_W = 16;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_OFFSET = 3'd3,
    ST_REMOVE = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [SAMPLE_W-1:0] write_sample;
    logic [ADDR_W-1:0]          read_offset;
    logic [CNT_W-1:0]           remove_count;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] read_sample;
    logic [2:0]                 status;
    logic [CNT_W-1:0]           fill_level;
  } out_rsp_t;

  // Advance a pointer below cap by step (step <= cap): one conditional subtract.
  function automatic logic [ADDR_W-1:0] wrap_add(
    input logic [ADDR_W-1:0] ptr,
    input logic [CNT_W-1:0]  step,
    input logic [CNT_W-1:0]  cap
  );
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, ptr} + {1'b0, step};
    if (sum >= {1'b0, cap}) begin
      sum = sum - {1'b0, cap};
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[src/rbop_mem.sv]
module rbop_mem (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [rbop_pkg::ADDR_W-1:0]           wr_addr,
  input  logic [rbop_pkg::SAMPLE_W-1:0]         wr_data,
  input  logic                                  rd_en,
  input  logic [rbop_pkg::ADDR_W-1:0]           rd_addr,
  output logic [rbop_pkg::SAMPLE_W-1:0]         rd_data
);

  logic [rbop_pkg::SAMPLE_W-1:0] store_r [rbop_pkg::DEPTH];
  logic [rbop_pkg::SAMPLE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ring_buffer_offset_peek.sv]
// Circular sample buffer with offset peek. Each request (insert, peek at an
// offset from the oldest sample, or remove a count of oldest samples) is
// taken when start is high and busy is low, and its single response appears
// on out_rsp with out_strobe high for exactly one cycle, the cycle right after
// the request was taken; the receiver cannot stall it, so it must capture
// the response in that cycle. One request per cycle is sustained while busy
// is low: pointers and the fill count live in registers and are updated at the
// request edge, while the peek data comes from the registered read port of the
// 1024 x 16 sample memory, read at the request edge. A
// request that cannot be done reports a nonzero status and changes nothing.
// Writing the capacity (cfg_we) empties the buffer; busy is high in that
// cycle and during reset, so no request is taken then. A capacity of zero
// acts as one and a value above 1024 acts as 1024.
module ring_buffer_offset_peek (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  rbop_pkg::in_req_t            in_req,
  output logic                         out_strobe,
  output rbop_pkg::out_rsp_t           out_rsp,
  input  logic                         cfg_we,
  input  logic [rbop_pkg::CNT_W-1:0]   cfg_wdata
);

  logic [rbop_pkg::CNT_W-1:0]    cap_r;
  logic [rbop_pkg::ADDR_W-1:0]   optr_r, optr_nxt;
  logic [rbop_pkg::ADDR_W-1:0]   wptr_r, wptr_nxt;
  logic [rbop_pkg::CNT_W-1:0]    held_r, held_nxt;
  logic                          out_valid_r;
  logic [2:0]                    status_r;
  rbop_pkg::status_t             status_nxt;
  logic [rbop_pkg::CNT_W-1:0]    fill_r;
  logic                          peek_ok_r, peek_ok_nxt;
  logic                          mem_we;
  logic [rbop_pkg::ADDR_W-1:0]   rd_addr;
  logic [rbop_pkg::SAMPLE_W-1:0] rd_data;
  logic [rbop_pkg::CNT_W-1:0]    cap_eff;
  logic                          accept;

  // Hold off requests during reset and in the cycle of a capacity write
  assign busy   = ~rst_n | cfg_we;
  assign accept = start & ~busy;

  // Clamp capacity to 1..DEPTH
  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = rbop_pkg::CNT_W'(1);
    end else if (cap_r > rbop_pkg::CNT_W'(rbop_pkg::DEPTH)) begin
      cap_eff = rbop_pkg::CNT_W'(rbop_pkg::DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign rd_addr = rbop_pkg::wrap_add(optr_r, {1'b0, in_req.read_offset}, cap_eff);

  // Decode the request against the current pointers and fill count
  always_comb begin
    optr_nxt    = optr_r;
    wptr_nxt    = wptr_r;
    held_nxt    = held_r;
    status_nxt  = rbop_pkg::ST_OK;
    peek_ok_nxt = 1'b0;
    mem_we      = 1'b0;
    unique case (in_req.operation)
      rbop_pkg::OP_INSERT: begin
        if (held_r >= cap_eff) begin
          status_nxt = rbop_pkg::ST_FULL;
        end else begin
          mem_we   = accept;
          held_nxt = held_r + rbop_pkg::CNT_W'(1);
          wptr_nxt = rbop_pkg::wrap_add(wptr_r, rbop_pkg::CNT_W'(1), cap_eff);
        end
      end
      rbop_pkg::OP_PEEK: begin
        priority if (held_r == '0) begin
          status_nxt = rbop_pkg::ST_EMPTY;
        end else if ({1'b0, in_req.read_offset} >= held_r) begin
          status_nxt = rbop_pkg::ST_OFFSET;
        end else begin
          peek_ok_nxt = 1'b1;
        end
      end
      rbop_pkg::OP_REMOVE: begin
        if (in_req.remove_count > held_r) begin
          status_nxt = rbop_pkg::ST_REMOVE;
        end else begin
          optr_nxt = rbop_pkg::wrap_add(optr_r, in_req.remove_count, cap_eff);
          held_nxt = held_r - in_req.remove_count;
        end
      end
      rbop_pkg::OP_NOP: begin
        status_nxt = rbop_pkg::ST_OK;
      end
      default: begin
        status_nxt = rbop_pkg::ST_OK;
      end
    endcase
  end

  // Pointer, fill and capacity registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= rbop_pkg::CNT_W'(rbop_pkg::DEPTH);
      optr_r <= '0;
      wptr_r <= '0;
      held_r <= '0;
    end else if (cfg_we) begin
      cap_r  <= cfg_wdata;
      optr_r <= '0;
      wptr_r <= '0;
      held_r <= '0;
    end else if (accept) begin
      optr_r <= optr_nxt;
      wptr_r <= wptr_nxt;
      held_r <= held_nxt;
    end
  end

  // Response strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // Response payload; the sample comes from the memory read register, loaded at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      fill_r    <= held_nxt;
      peek_ok_r <= peek_ok_nxt;
    end
  end

  rbop_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wptr_r),
    .wr_data (in_req.write_sample),
    .rd_en   (accept & peek_ok_nxt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_strobe          = out_valid_r;
  assign out_rsp.read_sample = peek_ok_r ? rd_data : '0;
  assign out_rsp.status      = status_r;
  assign out_rsp.fill_level  = fill_r;

endmodule

[src/rbop_chk.sv]
`include "ring_buffer_offset_peek_defines.svh"

module rbop_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input rbop_pkg::out_rsp_t         out_rsp,
  input logic                       cfg_we
);

  // Every request gets its response in the next cycle
  `RBOP_ASSERT_NEXT(a_rsp_follows, start && !busy, out_strobe, "request without response")

  // No response without a request
  `RBOP_ASSERT_NEXT(a_no_spurious, !(start && !busy), !out_strobe, "response without request")

  // Failed operations return a zero sample
  `RBOP_ASSERT_NOW(a_err_zero, out_strobe && (out_rsp.status != rbop_pkg::ST_OK), out_rsp.read_sample == '0, "sample on failed request")

  // Fill never exceeds the buffer depth
  `RBOP_ASSERT_NOW(a_fill_max, out_strobe, out_rsp.fill_level <= rbop_pkg::CNT_W'(rbop_pkg::DEPTH), "fill above depth")

  // Hold off requests while the capacity is written
  `RBOP_ASSERT_NOW(a_cfg_busy, cfg_we, busy, "not busy during capacity write")

endmodule

bind ring_buffer_offset_peek rbop_chk u_rbop_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp),
  .cfg_we     (cfg_we)
);

[tb/tb_ring_buffer_offset_peek.sv]
module tb_ring_buffer_offset_peek;
  import rbop_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 3;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_req_t          in_req = '0;
  logic             out_strobe;
  out_rsp_t         out_rsp;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  ring_buffer_offset_peek dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Requests waiting to be driven, and responses predicted for accepted requests
  in_req_t  queued_ops[$];
  out_rsp_t predicted_rsps[$];

  int unsigned idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;
  logic        took_req = 1'b0;

  // Shadow copy of the buffer
  logic signed [SAMPLE_W-1:0] shadow_store [DEPTH];
  int unsigned oldest_idx = 0;
  int unsigned free_idx = 0;
  int unsigned held_cnt = 0;
  int unsigned cap_setting = DEPTH;

  // Clamp the programmed capacity into 1..DEPTH
  function automatic int unsigned usable_capacity(input int unsigned c);
    if (c == 0) begin
      return 1;
    end
    return (c > DEPTH) ? DEPTH : c;
  endfunction

  // Move a ring index forward, wrapping once at lim
  function automatic int unsigned ring_advance(input int unsigned idx, input int unsigned step,
                                               input int unsigned lim);
    int unsigned s;
    s = idx + step;
    if (s >= lim) begin
      s = s - lim;
    end
    return s;
  endfunction

  // Predict the response to one request and update the shadow buffer
  task automatic apply_buffer_op(input in_req_t r, output out_rsp_t rsp);
    int unsigned lim;
    lim = usable_capacity(cap_setting);
    rsp = '0;
    rsp.status = ST_OK;
    case (op_t'(r.operation))
      OP_INSERT: begin
        if (held_cnt >= lim) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_store[free_idx] = r.write_sample;
          held_cnt = held_cnt + 1;
          free_idx = ring_advance(free_idx, 1, lim);
        end
      end
      OP_PEEK: begin
        if (held_cnt == 0) begin
          rsp.status = ST_EMPTY;
        end else if (r.read_offset >= held_cnt) begin
          rsp.status = ST_OFFSET;
        end else begin
          rsp.read_sample = shadow_store[ring_advance(oldest_idx, r.read_offset, lim)];
        end
      end
      OP_REMOVE: begin
        if (r.remove_count > held_cnt) begin
          rsp.status = ST_REMOVE;
        end else begin
          oldest_idx = ring_advance(oldest_idx, r.remove_count, lim);
          held_cnt = held_cnt - r.remove_count;
        end
      end
      default: begin
      end
    endcase
    rsp.fill_level = held_cnt[CNT_W-1:0];
  endtask

  task automatic log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic in_req_t mk_req(input op_t op, input logic [SAMPLE_W-1:0] smp,
                                     input int unsigned off, input int unsigned cnt);
    in_req_t r;
    r.operation    = op;
    r.write_sample = smp;
    r.read_offset  = ADDR_W'(off);
    r.remove_count = CNT_W'(cnt);
    return r;
  endfunction

  // Random request; offsets and counts lean toward the range 0..hint
  function automatic in_req_t make_random(input int unsigned hint, input int unsigned ins_pct);
    in_req_t     r;
    int unsigned pick;
    int unsigned top;
    r.write_sample = SAMPLE_W'($urandom());
    r.read_offset  = ADDR_W'($urandom());
    r.remove_count = CNT_W'($urandom());
    pick = $urandom_range(99, 0);
    if (pick < ins_pct) begin
      r.operation = OP_INSERT;
    end else if (pick < ins_pct + (100 - ins_pct) / 2) begin
      r.operation = OP_PEEK;
    end else if (pick < 97) begin
      r.operation = OP_REMOVE;
    end else begin
      r.operation = OP_NOP;
    end
    case ($urandom_range(7, 0))
      0: r.write_sample = 16'sh7fff;
      1: r.write_sample = 16'sh8000;
      default: begin
      end
    endcase
    top = (hint > DEPTH - 1) ? DEPTH - 1 : hint;
    if ($urandom_range(3, 0) != 0) begin
      r.read_offset = ADDR_W'($urandom_range(top, 0));
    end
    pick = $urandom_range(7, 0);
    if (pick < 5) begin
      r.remove_count = CNT_W'($urandom_range(2, 0));
    end else if (pick < 7) begin
      r.remove_count = CNT_W'($urandom_range((hint > DEPTH) ? DEPTH : hint, 0));
    end
    return r;
  endfunction

  // Wait until no request is queued or in flight, then let the pipe settle
  task automatic drain();
    while (queued_ops.size() != 0 || start || predicted_rsps.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input int unsigned value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int unsigned cap, input int unsigned pct,
                            input int unsigned n, input int unsigned ins_pct);
    set_capacity(cap);
    idle_pct = pct;
    repeat (n) queued_ops.push_back(make_random(usable_capacity(cap), ins_pct));
  endtask

  // Drive requests from the queue; hold a request until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_req) begin
      if (queued_ops.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        in_req <= queued_ops.pop_front();
        start  <= 1'b1;
      end else begin
        start  <= 1'b0;
      end
    end
  end

  // Check responses, track configuration and accepted requests, run the watchdog
  always @(posedge clk) begin : monitor
    out_rsp_t want;
    logic     accepted;
    accepted = rst_n && start && !busy;
    took_req <= accepted;
    if (rst_n) begin
      if (out_strobe) begin
        if (predicted_rsps.size() == 0) begin
          log_mismatch($sformatf("response with none pending: %p", out_rsp));
        end else begin
          want = predicted_rsps.pop_front();
          if (out_rsp.read_sample !== want.read_sample) begin
            log_mismatch($sformatf("read_sample expected %0d got %0d",
                                   want.read_sample, out_rsp.read_sample));
          end
          if (out_rsp.status !== want.status) begin
            log_mismatch($sformatf("status expected %0d got %0d",
                                   want.status, out_rsp.status));
          end
          if (out_rsp.fill_level !== want.fill_level) begin
            log_mismatch($sformatf("fill_level expected %0d got %0d",
                                   want.fill_level, out_rsp.fill_level));
          end
        end
      end
      // A capacity write empties the buffer but keeps the samples
      if (cfg_we) begin
        cap_setting = cfg_wdata;
        oldest_idx  = 0;
        free_idx    = 0;
        held_cnt    = 0;
      end
      if (accepted) begin
        apply_buffer_op(in_req, want);
        predicted_rsps.push_back(want);
      end
      if (accepted || out_strobe || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: error cases on empty, extremes, NOP, peek across the fill
    idle_pct = 0;
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 1));
    queued_ops.push_back(mk_req(OP_NOP, 16'h5a5a, 1023, 2047));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h7fff, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h8000, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'hffff, 0, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 3, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 4, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 1023, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 1024));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 2047));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 2));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));

    // Directed: capacity write empties a non-empty buffer; full and wrap at two
    set_capacity(2);
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h1234, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'hbeef, 0, 0));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h4321, 0, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 1));
    queued_ops.push_back(mk_req(OP_INSERT, 16'h4321, 0, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 1, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 2));

    // Random phases over several capacities and idle rates
    run_random(0, 62, 50, 50);
    run_random(5, 0, 80, 45);
    run_random(17, 20, 100, 55);

    // Clamp an oversized capacity, fill part way, then peek across the fill
    set_capacity(2047);
    idle_pct = 0;
    repeat (40) queued_ops.push_back(mk_req(OP_INSERT, SAMPLE_W'($urandom()), 0, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 39, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 0, 0));
    queued_ops.push_back(mk_req(OP_PEEK, 16'h0000, 40, 0));
    queued_ops.push_back(mk_req(OP_REMOVE, 16'h0000, 0, 30));
    drain();
    idle_pct = 20;
    repeat (60) queued_ops.push_back(make_random(40, 55));

    run_random(1, 62, 50, 50);
    run_random(700, 62, 80, 60);
    run_random(9, 20, 80, 50);
    run_random(1024, 0, 60, 50);

    drain();
    if (mismatch_cnt == 0 && predicted_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
